>>> rtl/lad_pkg.sv
// shared types and codes for the linear array deque
package lad_pkg;

    // operation codes carried in the input tuser
    localparam logic [1:0] KIND_INS_REAR  = 2'd0;
    localparam logic [1:0] KIND_INS_FRONT = 2'd1;
    localparam logic [1:0] KIND_DEL_FRONT = 2'd2;
    localparam logic [1:0] KIND_DEL_REAR  = 2'd3;

    // result status codes carried in the output tuser
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;

    // commands from controller to datapath
    typedef struct packed {
        logic exec;     // execute the operation presented at the input
        logic load_rd;  // move the slot read data into the result register
    } lad_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic rd_op;    // presented operation is a deletion that succeeds
    } lad_sts_t;

endpackage

>>> rtl/lad_datapath.sv
// pointers, slot memory and result register of the linear array deque
module lad_datapath
    import lad_pkg::*;
#(
    parameter int DEPTH      = 4,
    parameter int DATA_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [KIND_W-1:0]     in_kind,
    input  logic [DATA_WIDTH-1:0] in_data,
    input  lad_cmd_t              cmd,
    output lad_sts_t              sts,
    output logic [DATA_WIDTH-1:0] out_data,
    output logic [STATUS_W-1:0]   out_status
);

    localparam int PTR_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [PTR_W-1:0] PTR_DEPTH = PTR_W'(DEPTH);
    localparam logic [PTR_W-1:0] PTR_ONE   = PTR_W'(1);
    localparam logic [PTR_W-1:0] PTR_ZERO  = '0;

    logic [PTR_W-1:0]      front_reg, front_next;
    logic [PTR_W-1:0]      rear_reg, rear_next;
    logic [PTR_W-1:0]      front_inc, front_dec, rear_inc, rear_dec;
    logic [DATA_WIDTH-1:0] slot_mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic [DATA_WIDTH-1:0] out_data_reg;
    logic [STATUS_W-1:0]   out_status_reg;
    logic [ADDR_W-1:0]     wr_addr, rd_addr;
    logic                  wr_en;
    logic                  rd_op;
    logic                  empty;
    logic [STATUS_W-1:0]   op_status;

    assign front_inc = front_reg + PTR_ONE;
    assign front_dec = front_reg - PTR_ONE;
    assign rear_inc  = rear_reg + PTR_ONE;
    assign rear_dec  = rear_reg - PTR_ONE;
    assign empty     = (front_reg >= rear_reg);

    // decode the presented operation against the pointers
    always_comb
    begin
        front_next = front_reg;
        rear_next  = rear_reg;
        wr_en      = 1'b0;
        wr_addr    = rear_reg[ADDR_W-1:0];
        rd_addr    = front_reg[ADDR_W-1:0];
        rd_op      = 1'b0;
        op_status  = STATUS_OK;
        case (in_kind)
            KIND_INS_REAR:
            begin
                if (rear_reg == PTR_DEPTH)
                begin
                    op_status = STATUS_FULL;
                end
                else
                begin
                    wr_en     = 1'b1;
                    rear_next = rear_inc;
                end
            end
            KIND_INS_FRONT:
            begin
                if ((front_reg == PTR_ZERO) && (rear_reg == PTR_ZERO))
                begin
                    wr_en     = 1'b1;
                    wr_addr   = '0;
                    rear_next = PTR_ONE;
                end
                else if (front_reg != PTR_ZERO)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = front_dec[ADDR_W-1:0];
                    front_next = front_dec;
                end
                else
                begin
                    op_status = STATUS_FULL;
                end
            end
            KIND_DEL_FRONT:
            begin
                if (empty)
                begin
                    op_status = STATUS_EMPTY;
                end
                else
                begin
                    rd_op = 1'b1;
                    // the deque drains: both pointers go back to slot 0
                    if (front_inc >= rear_reg)
                    begin
                        front_next = PTR_ZERO;
                        rear_next  = PTR_ZERO;
                    end
                    else
                    begin
                        front_next = front_inc;
                    end
                end
            end
            default:
            begin
                if (empty)
                begin
                    op_status = STATUS_EMPTY;
                end
                else
                begin
                    rd_op     = 1'b1;
                    rd_addr   = rear_dec[ADDR_W-1:0];
                    rear_next = rear_dec;
                end
            end
        endcase
    end

    // pointer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            rear_reg  <= '0;
        end
        else if (cmd.exec)
        begin
            front_reg <= front_next;
            rear_reg  <= rear_next;
        end
    end

    // slot memory with registered read
    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_en)
        begin
            slot_mem[wr_addr] <= in_data;
        end
        if (cmd.exec)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            out_status_reg <= op_status;
            out_data_reg   <= '0;
        end
        else if (cmd.load_rd)
        begin
            out_data_reg <= rd_data_reg;
        end
    end

    assign sts.rd_op  = rd_op;
    assign out_data   = out_data_reg;
    assign out_status = out_status_reg;

endmodule

>>> rtl/lad_controller.sv
// handshake controller of the linear array deque
module lad_controller
    import lad_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  lad_sts_t sts,
    output lad_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic accept;

    // input is taken in the idle state once the result register is free or being emptied
    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.exec       = 1'b0;
        cmd.load_rd    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.exec = 1'b1;
                    if (sts.rd_op)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                cmd.load_rd    = 1'b1;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> rtl/linear_array_deque_unit.sv
// top level of the linear array deque
// Double-ended queue held in a non-wrapping array of DEPTH words, one result
// transaction per input transaction. Insertions, refused insertions and
// deletions from an empty deque load the result register directly; a
// successful deletion passes the registered slot memory read port and a
// read state, and the input is held off in that state. Outside it a new
// input transaction is taken as soon as the result register is empty or its
// transaction completes in the same cycle. Slots need no clearing after reset.
module linear_array_deque_unit
    import lad_pkg::*;
#(
    parameter int DEPTH      = 4,
    parameter int DATA_WIDTH = 32
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((DATA_WIDTH + 7) / 8) * 8-1:0] s_axis_tdata,  // data_in
    input  logic [KIND_W-1:0]                     s_axis_tuser,  // kind
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [((DATA_WIDTH + 7) / 8) * 8-1:0] m_axis_tdata,  // data_out
    output logic [STATUS_W-1:0]                   m_axis_tuser   // status
);

    localparam int TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;

    lad_cmd_t              cmd;
    lad_sts_t              sts;
    logic [DATA_WIDTH-1:0] out_data;

    lad_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    lad_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_kind    (s_axis_tuser),
        .in_data    (s_axis_tdata[DATA_WIDTH-1:0]),
        .cmd        (cmd),
        .sts        (sts),
        .out_data   (out_data),
        .out_status (m_axis_tuser)
    );

    // zero pad the result word up to whole bytes
    assign m_axis_tdata = TDATA_W'(out_data);

endmodule

>>> rtl/lad_checker.sv
// port level checks of the linear array deque and their binding
module lad_checker
    import lad_pkg::*;
#(
    parameter int DEPTH      = 4,
    parameter int DATA_WIDTH = 32
)
(
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  s_axis_tvalid,
    input logic                                  s_axis_tready,
    input logic                                  m_axis_tvalid,
    input logic                                  m_axis_tready,
    input logic [((DATA_WIDTH + 7) / 8) * 8-1:0] m_axis_tdata,
    input logic [STATUS_W-1:0]                   m_axis_tuser
);

    localparam int SLOT_BITS = $clog2(DEPTH + 1);

    // a stalled result transaction keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            ($stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

    // a refused or empty result carries a zero word
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != STATUS_OK)) |-> (m_axis_tdata == '0))
        else $error("nonzero word on failed operation");

    // no input is taken while a result is held back
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken over a stalled result");

    // an accepted input gives a result next cycle or blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && (SLOT_BITS > 0)) |=>
            (m_axis_tvalid || !s_axis_tready))
        else $error("accepted input neither answered nor held");

endmodule

bind linear_array_deque_unit lad_checker #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
) u_lad_checker (.*);
